// File: rtl/cmd_pkg.sv
// ----------------------------------------------------------------------------
// cmd_pkg: shared types and constants for the mass deposit grid.
// Holds the command and result word layouts, codes and defaults.
// ----------------------------------------------------------------------------
`default_nettype none
package cmd_pkg;
  localparam int GridSizeDefault = 64;
  localparam int AccW = 48;
  localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};
  localparam logic [31:0] ScaleReset = 32'd65536;
  localparam logic FuncDeposit = 1'b0;
  localparam logic FuncRead = 1'b1;
  localparam logic [1:0] RegGridScale = 2'd0;

  typedef struct packed {
    logic        func;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [17:0] cell_index;
  } cmd_t;

  typedef struct packed {
    logic [47:0] cell_value;
    logic        cell_saturated;
  } res_t;
endpackage
`default_nettype wire

// File: rtl/cmd_ram.sv
// ----------------------------------------------------------------------------
// cmd_ram: generic single-port synchronous RAM.
// One access per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module cmd_ram #(
  parameter int Width = 48,
  parameter int Depth = 1024
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(Depth)-1:0] addr,
  input  wire [Width-1:0]         wdata,
  output logic [Width-1:0]        rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: rtl/cmd_coord.sv
// ----------------------------------------------------------------------------
// cmd_coord: coordinate split for one axis.
// Registers pos*scale, then yields the wrapped cell, its neighbor and fraction.
// ----------------------------------------------------------------------------
`default_nettype none
module cmd_coord #(
  parameter int GridSize = 64,
  localparam int CW = (GridSize > 1) ? $clog2(GridSize) : 1
) (
  input  wire          clk,
  input  wire          load,
  input  wire [31:0]   pos,
  input  wire [31:0]   scale,
  output logic [CW-1:0] base,
  output logic [CW-1:0] base_nxt,
  output logic [15:0]  frac
);
  // 2^16 mod GridSize folds the upper half of the integer part down, and a
  // reciprocal multiply finishes the reduction of the folded value.
  localparam int Rem16  = (1 << 16) % GridSize;
  localparam int KShift = 26;
  localparam logic [25:0] Recip = 26'(((1 << KShift) + GridSize - 1) / GridSize);

  logic [63:0] prod;
  logic [23:0] fold1;
  logic [17:0] fold2;
  logic [17:0] fold;
  logic [43:0] qprod;
  logic [17:0] quo;
  logic [17:0] rem;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= 64'(pos) * 64'(scale);
    end
  end

  // Integer part is bits 63..32 of the raw product; its two folds stay
  // below 2^17, which the reciprocal divides exactly.
  assign fold1 = 24'(prod[63:48]) * 24'(Rem16) + 24'(prod[47:32]);
  assign fold2 = 18'(fold1[23:16]) * 18'(Rem16) + 18'(fold1[15:0]);

  always_ff @(posedge clk) begin
    fold <= fold2;
  end

  assign qprod = 44'(fold) * 44'(Recip);
  assign quo   = qprod[43:26];
  assign rem   = fold - 18'(quo * 18'(GridSize));

  always_ff @(posedge clk) begin
    base <= CW'(rem);
  end

  assign frac = prod[31:16];
  assign base_nxt = (32'(base) == 32'(GridSize - 1)) ? '0 : CW'(32'(base) + 32'd1);
endmodule
`default_nettype wire

// File: rtl/cic_mass_deposit_grid_unit.sv
// ----------------------------------------------------------------------------
// cic_mass_deposit_grid_unit: cloud-in-cell deposit into a periodic grid.
// A read raises its result strobe in StOut, the state after StRead, and the
// next word can be accepted once the block is back in StIdle.
// A deposit keeps busy high through coordinate setup (StMul for the product,
// then StMod for the modulo reduction) and 8 read-modify-write passes, each
// a StRd and a StWr, as the density RAM has a single port. One item at a time.
// After reset a clearing pass writes zero to all GridSize^3 cells, one per
// cycle (262144 cells at the default size); busy stays high meanwhile.
// The receiver cannot stall: each result strobe lasts exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module cic_mass_deposit_grid_unit #(
  parameter int GridSize = cmd_pkg::GridSizeDefault
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire cmd_pkg::cmd_t  cmd,
  output logic                busy,
  output logic                done,
  output cmd_pkg::res_t       result,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire [1:0]           paddr,
  input  wire [31:0]          pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  localparam int CW    = (GridSize > 1) ? $clog2(GridSize) : 1;
  localparam int Cells = GridSize * GridSize * GridSize;
  localparam int AW    = $clog2(Cells);

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StMul   = 3'd2;
  localparam logic [2:0] StRd    = 3'd3;
  localparam logic [2:0] StWr    = 3'd4;
  localparam logic [2:0] StRead  = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;
  localparam logic [2:0] StMod   = 3'd7;

  logic [2:0]    state;
  logic [31:0]   grid_scale;
  logic [AW:0]   clr_cnt;
  logic [2:0]    corner;
  logic          rd_ok;
  logic [AW-1:0] rd_addr;

  // The APB port: one register, written in the access phase.
  assign pready = 1'b1;
  assign prdata = (paddr == cmd_pkg::RegGridScale) ? grid_scale : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_scale <= cmd_pkg::ScaleReset;
    end else if (psel && penable && pwrite && pready && paddr == cmd_pkg::RegGridScale) begin
      grid_scale <= pwdata;
    end
  end

  // Coordinate units, one per axis, loaded on accept. The product is ready
  // in StMul, the folded value in StMod, and the wrapped cell from StRd on.
  logic accept;
  logic [CW-1:0] cx0, cx1, cy0, cy1, cz0, cz1;
  logic [15:0]   fx, fy, fz;
  assign accept = start && !busy;

  cmd_coord #(.GridSize(GridSize)) u_x (
    .clk(clk), .load(accept), .pos(cmd.pos_x), .scale(grid_scale),
    .base(cx0), .base_nxt(cx1), .frac(fx));
  cmd_coord #(.GridSize(GridSize)) u_y (
    .clk(clk), .load(accept), .pos(cmd.pos_y), .scale(grid_scale),
    .base(cy0), .base_nxt(cy1), .frac(fy));
  cmd_coord #(.GridSize(GridSize)) u_z (
    .clk(clk), .load(accept), .pos(cmd.pos_z), .scale(grid_scale),
    .base(cz0), .base_nxt(cz1), .frac(fz));

  // Per-corner weight: the xy product is registered before the z multiply.
  logic [16:0] wx, wy, wz;
  logic [33:0] wxy;
  logic [47:0] wgt;
  logic [50:0] wfull;
  logic [CW-1:0] sx, sy, sz;

  assign wx = corner[2] ? {1'b0, fx} : 17'h10000 - {1'b0, fx};
  assign wy = corner[1] ? {1'b0, fy} : 17'h10000 - {1'b0, fy};
  assign wz = corner[0] ? {1'b0, fz} : 17'h10000 - {1'b0, fz};
  assign sx = corner[2] ? cx1 : cx0;
  assign sy = corner[1] ? cy1 : cy0;
  assign sz = corner[0] ? cz1 : cz0;

  // The xy product is taken during StRd, the z multiply during StWr.
  always_ff @(posedge clk) begin
    wxy <= 34'(wx) * 34'(wy);
  end
  assign wfull = 51'(wxy) * 51'(wz);
  assign wgt   = 48'(wfull >> 24);

  // Flat address of the current corner.
  logic [AW-1:0] dep_addr;
  assign dep_addr = AW'((((32'(sx) * 32'(GridSize)) + 32'(sy)) * 32'(GridSize)) + 32'(sz));

  // Density RAM.
  logic            we;
  logic [AW-1:0]   addr;
  logic [47:0]     wdata, rdata;
  logic [48:0]     sum;

  assign sum   = {1'b0, rdata} + {1'b0, wgt};
  assign wdata = (state == StClear) ? '0 : (sum[48] ? cmd_pkg::AccMax : sum[47:0]);
  assign we    = (state == StClear) || (state == StWr);

  always_comb begin
    case (state)
      StClear: addr = clr_cnt[AW-1:0];
      StRd, StWr: addr = dep_addr;
      default: addr = rd_addr;
    endcase
  end

  cmd_ram #(.Width(cmd_pkg::AccW), .Depth(Cells)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= StClear;
      clr_cnt <= '0;
      corner  <= '0;
    end else begin
      case (state)
        StClear: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AW+1)'(Cells - 1)) begin
            state <= StIdle;
          end
        end
        StIdle: begin
          if (start) begin
            if (cmd.func == cmd_pkg::FuncRead) begin
              state <= StRead;
            end else begin
              state <= StMul;
            end
          end
        end
        StMul: begin
          corner <= '0;
          state  <= StMod;
        end
        StMod: state <= StRd;
        StRd: state <= StWr;
        StWr: begin
          corner <= corner + 1'b1;
          state  <= (corner == 3'd7) ? StIdle : StRd;
        end
        StRead: state <= StOut;
        StOut: state <= StIdle;
        default: state <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_ok   <= 32'(cmd.cell_index) < 32'(Cells);
      rd_addr <= AW'(cmd.cell_index);
    end
  end

  assign busy = (state != StIdle);
  assign done = (state == StOut);
  assign result.cell_value     = rd_ok ? rdata : '0;
  assign result.cell_saturated = rd_ok && (rdata == cmd_pkg::AccMax);
endmodule
`default_nettype wire

// File: dv/tb_cic_mass_deposit_grid_unit.sv
// ----------------------------------------------------------------------------
// tb_cic_mass_deposit_grid_unit: self-checking bench for the CIC deposit grid.
// Deposits and reads are sent through the start/busy handshake. The bench
// keeps its own copy of the density grid and the grid_scale register, and
// checks every read result strobe against the predicted cell value.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_cic_mass_deposit_grid_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Grid = cmd_pkg::GridSizeDefault;
  localparam int CellCount = Grid * Grid * Grid;
  // The clearing pass after reset visits every cell, so the idle
  // limit must sit well above the grid size cubed.
  localparam int IdleLimit = 4 * CellCount + 1000;
  // A deposit is the longest operation; settle a bit longer.
  localparam int SettleCycles = 30;

  logic           clk;
  logic           rst;
  logic           start;
  cmd_pkg::cmd_t  cmd;
  logic           busy;
  logic           done;
  cmd_pkg::res_t  result;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [1:0]     paddr;
  logic [31:0]    pwdata;
  logic [31:0]    prdata;
  logic           pready;

  cic_mass_deposit_grid_unit u_top (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .busy(busy), .done(done),
    .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // The bench's own copy of the grid. Only touched cells are stored; any
  // cell missing from the map is still zero from the clearing pass.
  logic [cmd_pkg::AccW-1:0] density_map [int];
  logic [31:0]              scale_q16;
  cmd_pkg::res_t            pending_reads[$];
  int                       touched_cells[$];
  int                       mismatches;
  int                       idle_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Split one coordinate into its wrapped cell, the next cell and the
  // Q0.16 fraction, following (pos * scale) >> 16.
  function automatic void split_axis(input logic [31:0] pos, output int base,
                                     output int nxt, output logic [16:0] frac);
    logic [63:0] coord;
    coord = ({32'd0, pos} * {32'd0, scale_q16}) >> 16;
    frac  = {1'b0, coord[15:0]};
    base  = int'((coord >> 16) % Grid);
    nxt   = (base + 1) % Grid;
  endfunction

  function automatic void deposit_particle(input cmd_pkg::cmd_t c);
    int          cx[2];
    int          cy[2];
    int          cz[2];
    logic [16:0] fx, fy, fz;
    logic [63:0] wx[2];
    logic [63:0] wy[2];
    logic [63:0] wz[2];
    logic [63:0] weight;
    logic [63:0] total;
    int          idx;
    split_axis(c.pos_x, cx[0], cx[1], fx);
    split_axis(c.pos_y, cy[0], cy[1], fy);
    split_axis(c.pos_z, cz[0], cz[1], fz);
    wx[0] = 64'd65536 - fx; wx[1] = fx;
    wy[0] = 64'd65536 - fy; wy[1] = fy;
    wz[0] = 64'd65536 - fz; wz[1] = fz;
    for (int a = 0; a < 2; a++) begin
      for (int b = 0; b < 2; b++) begin
        for (int k = 0; k < 2; k++) begin
          weight = (wx[a] * wy[b] * wz[k]) >> 24;
          idx = (cx[a] * Grid + cy[b]) * Grid + cz[k];
          total = weight;
          if (density_map.exists(idx)) begin
            total = total + density_map[idx];
          end else begin
            touched_cells.push_back(idx);
          end
          // The accumulator sticks at its maximum instead of wrapping.
          if (total > {16'd0, cmd_pkg::AccMax}) begin
            total = {16'd0, cmd_pkg::AccMax};
          end
          density_map[idx] = total[cmd_pkg::AccW-1:0];
        end
      end
    end
  endfunction

  function automatic cmd_pkg::res_t read_cell(input logic [17:0] index);
    cmd_pkg::res_t r;
    logic [cmd_pkg::AccW-1:0] v;
    v = '0;
    if (index < CellCount && density_map.exists(int'(index))) begin
      v = density_map[int'(index)];
    end
    r.cell_value = v;
    r.cell_saturated = (v == cmd_pkg::AccMax);
    return r;
  endfunction

  // Send one word after a random gap and fold it into the prediction at
  // the edge where it is accepted. On return start is still high.
  task automatic send_word(input cmd_pkg::cmd_t c);
    int gap;
    gap = $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) begin
      gap = 0;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    forever begin
      @(negedge clk);
      if (!busy) begin
        break;
      end
    end
    @(posedge clk);
    if (c.func == cmd_pkg::FuncDeposit) begin
      deposit_particle(c);
    end else begin
      pending_reads.push_back(read_cell(c.cell_index));
    end
  endtask

  function automatic cmd_pkg::cmd_t deposit_word(input logic [31:0] x,
                                                 input logic [31:0] y,
                                                 input logic [31:0] z);
    cmd_pkg::cmd_t c;
    c.func = cmd_pkg::FuncDeposit;
    c.pos_x = x;
    c.pos_y = y;
    c.pos_z = z;
    c.cell_index = 18'($urandom());
    return c;
  endfunction

  function automatic cmd_pkg::cmd_t read_word(input logic [17:0] index);
    cmd_pkg::cmd_t c;
    c.func = cmd_pkg::FuncRead;
    c.pos_x = $urandom();
    c.pos_y = $urandom();
    c.pos_z = $urandom();
    c.cell_index = index;
    return c;
  endfunction

  // Wait until the block has drained: all reads answered, busy low, and
  // enough cycles for a trailing deposit to finish.
  task automatic wait_drained();
    start <= 1'b0;
    wait (pending_reads.size() == 0);
    forever begin
      @(negedge clk);
      if (!busy) begin
        break;
      end
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; pready is always high.
  task automatic write_scale(input logic [31:0] value);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= cmd_pkg::RegGridScale;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    scale_q16 = value;
  endtask

  // Directed part: whole-cell deposits, the far corner with wrap-around,
  // half-cell fractions, and reads at both ends of the index range.
  task automatic test_directed();
    write_scale(cmd_pkg::ScaleReset);
    send_word(read_word(18'd0));
    send_word(deposit_word(32'd0, 32'd0, 32'd0));
    send_word(read_word(18'd0));
    send_word(read_word(18'd1));
    send_word(deposit_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(read_word(18'h3FFFF));
    send_word(read_word(18'd0));
    send_word(read_word(18'(Grid * Grid * (Grid - 1))));
    send_word(deposit_word(32'h0000_8000, 32'h0001_8000, 32'h0002_8000));
    send_word(read_word(18'((0 * Grid + 1) * Grid + 2)));
    send_word(read_word(18'((1 * Grid + 2) * Grid + 3)));
    send_word(deposit_word(32'h003F_0001, 32'h0000_FFFF, 32'h0040_0000));
    send_word(read_word(18'((63 * Grid + 0) * Grid + 0)));
    send_word(read_word(18'((0 * Grid + 1) * Grid + 1)));
  endtask

  // Scale at both extremes: zero folds every particle onto cell zero with
  // a zero fraction, all ones stretches positions far past the grid.
  task automatic test_scale_extremes();
    write_scale(32'd0);
    repeat (4) begin
      send_word(deposit_word($urandom(), $urandom(), $urandom()));
    end
    send_word(read_word(18'd0));
    write_scale(32'hFFFF_FFFF);
    send_word(deposit_word(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000));
    send_word(read_word(18'(touched_cells[touched_cells.size() - 1])));
    send_word(read_word(18'(touched_cells[touched_cells.size() - 2])));
  endtask

  // Random part: deposits and, most often, reads of cells that were hit,
  // with some reads anywhere in the grid.
  task automatic test_random(input logic [31:0] value, input int count);
    cmd_pkg::cmd_t c;
    write_scale(value);
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          if ($urandom_range(0, 1) == 0) begin
            c = deposit_word($urandom(), $urandom(), $urandom());
          end else begin
            c = deposit_word($urandom_range(0, 32'h00FF_FFFF),
                             $urandom_range(0, 32'h00FF_FFFF),
                             $urandom_range(0, 32'h00FF_FFFF));
          end
        end
        4, 5, 6, 7, 8: begin
          c = read_word(18'(touched_cells[$urandom_range(0, touched_cells.size() - 1)]));
        end
        default: begin
          c = read_word(18'($urandom()));
        end
      endcase
      send_word(c);
    end
  endtask

  // Each result strobe lasts one cycle; sample it mid-cycle.
  always @(negedge clk) begin
    cmd_pkg::res_t want;
    if (!rst && done) begin
      if (pending_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result word: value %h sat %b",
                   result.cell_value, result.cell_saturated);
        end
      end else begin
        want = pending_reads.pop_front();
        if (result.cell_value !== want.cell_value ||
            result.cell_saturated !== want.cell_saturated) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("read mismatch: expected value %h sat %b, got value %h sat %b",
                     want.cell_value, want.cell_saturated,
                     result.cell_value, result.cell_saturated);
          end
        end
      end
    end
  end

  // Watchdog on cycles where no word moves in either direction.
  always @(negedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    cmd         = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    mismatches  = 0;
    idle_cycles = 0;
    scale_q16   = cmd_pkg::ScaleReset;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_scale_extremes();
    test_random(cmd_pkg::ScaleReset, 270);
    test_random(32'h0000_4000, 270);
    test_random($urandom(), 270);
    test_random($urandom_range(32'h0001_0000, 32'h0010_0000), 270);
    wait_drained();
    if (mismatches == 0 && pending_reads.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
rtl/cmd_pkg.sv
rtl/cmd_ram.sv
rtl/cmd_coord.sv
rtl/cic_mass_deposit_grid_unit.sv
dv/tb_cic_mass_deposit_grid_unit.sv
